@@ hdl/seqt_pkg.sv @@
package seqt_pkg;

	// Table geometry
	localparam int ENTRIES   = 16;
	localparam int SEQ_WIDTH = 32;

	// Entry index and fill count widths
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// Field widths of the transactions
	localparam int FUNC_W  = 3;
	localparam int ADDR_W  = 32;
	localparam int VALUE_W = 32;

	// Operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_READ_ACK   = 3'd0,
		FN_INC_ACK    = 3'd1,
		FN_TAKE_SEND  = 3'd2,
		FN_READ_EXP   = 3'd3,
		FN_INC_EXP    = 3'd4
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_NEW   = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Request and response payloads
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
	} rsp_t;

	// The three counters of one entry, stored side by side
	typedef struct packed {
		logic [SEQ_WIDTH-1:0] ack;
		logic [SEQ_WIDTH-1:0] send;
		logic [SEQ_WIDTH-1:0] expect_seq;
	} cnt_set_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_CNT_RD,
		S_UPDATE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic start;     // capture request, restart the scan
		logic scan;      // advance the key scan
		logic hit_take;  // matching entry found, latch its slot
		logic commit;    // write back and load the response register
	} seqt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic match;      // compared key equals the request address
		logic scan_done;  // all used entries compared, no match
		logic out_free;   // response register can take a new result
	} seqt_sts_t;

endpackage

@@ hdl/seqt_ram.sv @@
module seqt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/seqt_ctrl.sv @@
module seqt_ctrl
	import seqt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  seqt_sts_t sts,
	output seqt_cmd_t cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.match) begin
					cmd.hit_take = 1'b1;
					state_d      = S_CNT_RD;
				end else if (sts.scan_done) begin
					state_d = S_UPDATE;
				end
			end
			S_CNT_RD: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Checks
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("commit while response register busy");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == S_SCAN))
		else $error("scan did not follow request capture");

endmodule

@@ hdl/seqt_dpath.sv @@
module seqt_dpath
	import seqt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  req_t      req,
	input  seqt_cmd_t cmd,
	output seqt_sts_t sts,
	output rsp_t      rsp,
	output logic      rsp_valid,
	input  logic      rsp_ready
);

	req_t             req_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic             cmp_v_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic [IDX_W-1:0] slot_q;
	logic             hit_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic [ADDR_W-1:0] key_rdata;
	logic              key_we;
	logic [IDX_W-1:0]  alloc_idx;
	cnt_set_t          cnt_rdata;
	cnt_set_t          cnt_base;
	cnt_set_t          cnt_new;
	logic              cnt_we;
	logic [IDX_W-1:0]  cnt_waddr;
	logic              issue;
	logic              full;
	logic              full_miss;
	logic              alloc;
	logic [SEQ_WIDTH-1:0] val;
	rsp_t              rsp_d;

	// Scan control
	assign issue     = scan_idx_q < used_q;
	assign full      = (used_q == CNT_W'(ENTRIES));
	assign full_miss = !hit_q && full;
	assign alloc     = !hit_q && !full;
	assign alloc_idx = used_q[IDX_W-1:0];

	assign sts.match     = cmp_v_q && (key_rdata == req_q.address);
	assign sts.scan_done = !issue && !cmp_v_q;
	assign sts.out_free  = !out_valid_q || rsp_ready;

	// Key store, read by the scan index
	assign key_we = cmd.commit && alloc;

	seqt_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(alloc_idx),
		.wdata(req_q.address),
		.raddr(scan_idx_q[IDX_W-1:0]),
		.rdata(key_rdata)
	);

	// Counter store, read at the selected slot
	assign cnt_we    = cmd.commit && !full_miss;
	assign cnt_waddr = hit_q ? slot_q : alloc_idx;

	seqt_ram #(
		.WIDTH($bits(cnt_set_t)),
		.DEPTH(ENTRIES)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_new),
		.raddr(slot_q),
		.rdata(cnt_rdata)
	);

	// Counter update: a fresh entry starts from zero
	always_comb begin
		cnt_base = hit_q ? cnt_rdata : '0;
		cnt_new  = cnt_base;
		val      = '0;
		unique case (func_t'(req_q.func))
			FN_READ_ACK: begin
				val = cnt_base.ack;
			end
			FN_INC_ACK: begin
				cnt_new.ack = cnt_base.ack + SEQ_WIDTH'(1);
			end
			FN_TAKE_SEND: begin
				val          = cnt_base.send;
				cnt_new.send = cnt_base.send + SEQ_WIDTH'(1);
			end
			FN_READ_EXP: begin
				val = cnt_base.expect_seq;
			end
			FN_INC_EXP: begin
				cnt_new.expect_seq = cnt_base.expect_seq + SEQ_WIDTH'(1);
			end
			default: begin
				// unknown op: lookup only
			end
		endcase
	end

	// Response value and status
	always_comb begin
		if (full_miss) begin
			rsp_d.value  = '0;
			rsp_d.status = ST_FULL;
		end else begin
			rsp_d.value  = VALUE_W'(val);
			rsp_d.status = hit_q ? ST_FOUND : ST_NEW;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			cmp_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				cmp_v_q <= 1'b0;
			end else if (cmd.scan) begin
				cmp_v_q <= issue;
			end
			if (cmd.commit && alloc) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, scan position, slot and response payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q      <= req;
			scan_idx_q <= '0;
			hit_q      <= 1'b0;
		end else if (cmd.scan) begin
			cmp_idx_q <= scan_idx_q[IDX_W-1:0];
			if (issue) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
		end
		if (cmd.hit_take) begin
			slot_q <= cmp_idx_q;
			hit_q  <= 1'b1;
		end
		if (cmd.commit) begin
			out_q <= rsp_d;
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

	// Checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(ENTRIES))
		else $error("fill count beyond table size");

	a_full_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && full_miss) |=> $stable(used_q))
		else $error("full table changed its fill count");

	a_match_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && sts.match) |-> (CNT_W'(cmp_idx_q) < used_q))
		else $error("match on an unused entry");

endmodule

@@ hdl/sequence_number_table.sv @@
// Channel  Direction  Payload  Handshake
// req      in         req_t    req_valid / req_ready
// rsp      out        rsp_t    rsp_valid / rsp_ready
//
// A request is accepted only in the idle state, so one is through before the
// next is taken. The key store is compared one entry per cycle through its
// registered read port, and a hit then reads its counters from the counter
// store. The update and response load follow once the response register is
// free, and the idle state takes the next request. A full table has 16 entries.
// Reset empties the table at once (fill count to zero), no clearing pass.
// A waiting response does not block the next request; only its write-back
// waits until the response register is free.
module sequence_number_table
	import seqt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	seqt_cmd_t cmd;
	seqt_sts_t sts;

	seqt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	seqt_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

endmodule

@@ bench/sequence_number_table_tb.sv @@
module sequence_number_table_tb;
	import seqt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Codes outside the operation set; the block must still look up or allocate
	localparam logic [FUNC_W-1:0] FN_RSVD_LO  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_RSVD_MID = 3'd6;
	localparam logic [FUNC_W-1:0] FN_RSVD_HI  = 3'd7;

	localparam int RANDOM_ITEMS  = 700;
	localparam int GAP_PCT       = 29;
	localparam int HOLD_CYCLES   = 250;
	localparam int STALL_LIMIT   = 3000;
	localparam int TAIL_CYCLES   = 40;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// One row of the directed sequence; typed rows carry their own answer
	typedef struct {
		logic [FUNC_W-1:0]  func;
		logic [ADDR_W-1:0]  address;
		bit                 typed;
		logic [VALUE_W-1:0] value;
		status_t            status;
	} lookup_row_t;

	typedef struct {
		bit   typed;
		rsp_t answer;
	} typed_note_t;

	// Shadow copy of the table
	logic [ADDR_W-1:0]    tbl_key  [ENTRIES];
	logic [SEQ_WIDTH-1:0] tbl_ack  [ENTRIES];
	logic [SEQ_WIDTH-1:0] tbl_send [ENTRIES];
	logic [SEQ_WIDTH-1:0] tbl_exp  [ENTRIES];
	int                   tbl_used = 0;

	rsp_t          expected_rsp_q[$];
	typed_note_t   typed_note_q[$];
	logic [ADDR_W-1:0] stored_keys[$];
	lookup_row_t   dir_rows[$];

	int mismatch_count = 0;
	int stall_cycles   = 0;
	int req_gap_pct    = GAP_PCT;
	int rsp_gap_pct    = GAP_PCT;
	bit rsp_hold       = 1'b0;

	sequence_number_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Scan for the key, allocate on a miss, then apply the operation
	function automatic rsp_t predict_lookup(input req_t item);
		rsp_t res;
		int   slot;
		bit   hit;
		int   i;
		res.value  = '0;
		res.status = ST_FOUND;
		slot       = 0;
		hit        = 1'b0;
		for (i = 0; i < tbl_used; i++) begin
			if (!hit && tbl_key[i] == item.address) begin
				slot = i;
				hit  = 1'b1;
			end
		end
		if (!hit) begin
			if (tbl_used >= ENTRIES) begin
				res.status = ST_FULL;
				return res;
			end
			slot           = tbl_used;
			tbl_key[slot]  = item.address;
			tbl_ack[slot]  = '0;
			tbl_send[slot] = '0;
			tbl_exp[slot]  = '0;
			tbl_used++;
			res.status     = ST_NEW;
		end
		unique case (item.func)
			FN_READ_ACK:  res.value = VALUE_W'(tbl_ack[slot]);
			FN_INC_ACK:   tbl_ack[slot] = tbl_ack[slot] + SEQ_WIDTH'(1);
			FN_TAKE_SEND: begin
				res.value      = VALUE_W'(tbl_send[slot]);
				tbl_send[slot] = tbl_send[slot] + SEQ_WIDTH'(1);
			end
			FN_READ_EXP:  res.value = VALUE_W'(tbl_exp[slot]);
			FN_INC_EXP:   tbl_exp[slot] = tbl_exp[slot] + SEQ_WIDTH'(1);
			default:      ;
		endcase
		return res;
	endfunction

	// Present one request, with random gaps ahead of it, until accepted
	task automatic send_request(input req_t item, input bit typed, input rsp_t answer);
		typed_note_t note;
		bit          known;
		int          i;
		known = 1'b0;
		for (i = 0; i < stored_keys.size(); i++)
			if (stored_keys[i] == item.address)
				known = 1'b1;
		if (!known && stored_keys.size() < ENTRIES)
			stored_keys.push_back(item.address);
		while ($urandom_range(0, 99) < req_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		note.typed  = typed;
		note.answer = answer;
		typed_note_q.push_back(note);
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	// Transaction monitor: predict on request accept, check on response accept
	always @(posedge clk) begin : monitor
		rsp_t        predicted;
		rsp_t        want;
		typed_note_t note;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predicted = predict_lookup(req);
				note      = typed_note_q.pop_front();
				expected_rsp_q.push_back(note.typed ? note.answer : predicted);
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: response with none expected, actual value %h status %0d",
						$time, rsp.value, rsp.status);
					mismatch_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.value !== want.value) begin
						$display("%0t: value mismatch, expected %h, actual %h",
							$time, want.value, rsp.value);
						mismatch_count++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, rsp.status);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Response side: random back-pressure plus one long hold-off on request
	initial begin : rsp_side
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_hold) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_hold = 1'b0;
			end
			rsp_ready <= ($urandom_range(0, 99) >= rsp_gap_pct);
		end
	end

	// Watchdog: cycles with no transaction on either channel
	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t: timeout, %0d responses outstanding", $time, expected_rsp_q.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		req_t item;
		rsp_t answer;
		int   i;
		int   n;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;

		// Directed: both address extremes, each operation, reserved codes,
		// filling the table, a request on a full table, a hit on the last slot
		dir_rows.push_back('{FN_READ_ACK,  32'h0000_0000, 1'b1, 32'd0, ST_NEW});
		dir_rows.push_back('{FN_INC_ACK,   32'h0000_0000, 1'b1, 32'd0, ST_FOUND});
		dir_rows.push_back('{FN_READ_ACK,  32'h0000_0000, 1'b1, 32'd1, ST_FOUND});
		dir_rows.push_back('{FN_TAKE_SEND, 32'hFFFF_FFFF, 1'b1, 32'd0, ST_NEW});
		dir_rows.push_back('{FN_TAKE_SEND, 32'hFFFF_FFFF, 1'b0, 32'd0, ST_FOUND});
		dir_rows.push_back('{FN_INC_EXP,   32'hFFFF_FFFF, 1'b1, 32'd0, ST_FOUND});
		dir_rows.push_back('{FN_READ_EXP,  32'hFFFF_FFFF, 1'b0, 32'd0, ST_FOUND});
		dir_rows.push_back('{FN_RSVD_LO,   32'hA5A5_A5A5, 1'b1, 32'd0, ST_NEW});
		dir_rows.push_back('{FN_RSVD_HI,   32'h0000_0000, 1'b1, 32'd0, ST_FOUND});
		dir_rows.push_back('{FN_RSVD_MID,  32'hA5A5_A5A5, 1'b1, 32'd0, ST_FOUND});
		dir_rows.push_back('{FN_INC_ACK,   32'h5A5A_5A5A, 1'b1, 32'd0, ST_NEW});
		dir_rows.push_back('{FN_READ_ACK,  32'h5A5A_5A5A, 1'b0, 32'd0, ST_FOUND});
		for (i = 0; i < ENTRIES - 4; i++)
			dir_rows.push_back('{FUNC_W'(i % 5), 32'h8000_0000 >> (2 * i), 1'b0, '0,
				ST_FOUND});
		dir_rows.push_back('{FN_READ_ACK,  32'h1357_2468, 1'b1, 32'd0, ST_FULL});
		dir_rows.push_back('{FN_TAKE_SEND, 32'h8000_0000 >> (2 * (ENTRIES - 5)), 1'b0,
			32'd0, ST_FOUND});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			item.func     = dir_rows[i].func;
			item.address  = dir_rows[i].address;
			answer.value  = dir_rows[i].value;
			answer.status = dir_rows[i].status;
			send_request(item, dir_rows[i].typed, answer);
		end

		// Random: mostly hits on stored keys, some fresh keys against the full table
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 100) begin
				req_gap_pct = 0;
				rsp_gap_pct = 0;
				rsp_hold    = 1'b1;
			end
			if (n == 260) begin
				req_gap_pct = GAP_PCT;
				rsp_gap_pct = GAP_PCT;
			end
			if ($urandom_range(0, 99) < 90)
				item.func = FUNC_W'($urandom_range(FN_READ_ACK, FN_INC_EXP));
			else
				item.func = FUNC_W'($urandom_range(FN_RSVD_LO, FN_RSVD_HI));
			if (stored_keys.size() != 0 && $urandom_range(0, 99) < 85)
				item.address = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
			else
				item.address = $urandom;
			send_request(item, 1'b0, '0);
		end
		req_valid <= 1'b0;

		// Drain, then let the block settle
		@(posedge clk);
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_rsp_q.size() != 0 || typed_note_q.size() != 0)
			mismatch_count++;

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
hdl/seqt_pkg.sv
hdl/seqt_ram.sv
hdl/seqt_ctrl.sv
hdl/seqt_dpath.sv
hdl/sequence_number_table.sv
bench/sequence_number_table_tb.sv
